// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define GSPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define GSPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gspi_pkg.sv =====
// ----------------------------------------------------------------------------
// gspi_pkg
// types, widths, constants and sequencer op codes of the pi speed loop
// ----------------------------------------------------------------------------
package gspi_pkg;

  // field and datapath widths
  localparam int SPEED_W    = 14;
  localparam int ERR_W      = 15;
  localparam int AC_W       = 10;
  localparam int FAC_W      = 18;
  localparam int MA_W       = 37;
  localparam int MB_W       = 19;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int FV_W       = 40;
  localparam int SUM_W      = 36;
  localparam int KP_W       = 23;
  localparam int KI_W       = 26;
  localparam int KI_LO_W    = 13;
  localparam int ACC_W      = 62;
  localparam int P_W        = 22;
  localparam int IT_W       = 30;
  localparam int DRV_W      = 13;
  localparam int OSUM_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ERR_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_NEG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_BASE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KI_BASE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_SCALE  = 3'd6;

  // gain schedule slopes, q32
  localparam logic signed [MA_W-1:0] K_KPN = MA_W'(1216764);
  localparam logic signed [MA_W-1:0] K_KIN = MA_W'(2075758);
  localparam logic signed [MA_W-1:0] K_KPE = MA_W'(9543417);
  localparam logic signed [MA_W-1:0] K_SKE = MA_W'(-4771709);

  // gain schedule offsets and clamps, q32
  localparam logic signed [FV_W-1:0] B_KPN  = FV_W'(-64'sd572519141);
  localparam logic signed [FV_W-1:0] B_KIN  = FV_W'(-64'sd787267505);
  localparam logic signed [FV_W-1:0] B_KPE  = FV_W'(64'sd3340625563);
  localparam logic signed [FV_W-1:0] B_SKE  = FV_W'(64'sd4771708666);
  localparam logic signed [FV_W-1:0] LO_KPN = FV_W'(64'sd644245094);
  localparam logic signed [FV_W-1:0] HI_KPN = FV_W'(64'sd4294967296);
  localparam logic signed [FV_W-1:0] LO_KIN = FV_W'(64'sd1288490189);
  localparam logic signed [FV_W-1:0] HI_KIN = FV_W'(64'sd7516192768);
  localparam logic signed [FV_W-1:0] LO_KPE = FV_W'(64'sd4294967296);
  localparam logic signed [FV_W-1:0] HI_KPE = FV_W'(64'sd12884901888);
  localparam logic signed [FV_W-1:0] LO_SKE = FV_W'(64'sd0);
  localparam logic signed [FV_W-1:0] HI_SKE = FV_W'(64'sd4294967296);

  // error magnitude clamp for the error-driven factors
  localparam logic [AC_W-1:0] ERR_LO = AC_W'(100);
  localparam logic [AC_W-1:0] ERR_HI = AC_W'(1000);

  // sequencer op codes, used both for the multiplier issue and the writeback
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE = 4'd0;
  localparam op_t OP_KPN  = 4'd1;
  localparam op_t OP_KIN  = 4'd2;
  localparam op_t OP_KPE  = 4'd3;
  localparam op_t OP_SKE  = 4'd4;
  localparam op_t OP_KB   = 4'd5;
  localparam op_t OP_KIB  = 4'd6;
  localparam op_t OP_KP1  = 4'd7;
  localparam op_t OP_KI1  = 4'd8;
  localparam op_t OP_KP2  = 4'd9;
  localparam op_t OP_INC  = 4'd10;
  localparam op_t OP_P    = 4'd11;
  localparam op_t OP_IH   = 4'd12;
  localparam op_t OP_IL   = 4'd13;
  localparam op_t OP_ITR  = 4'd14;
  localparam op_t OP_OUT  = 4'd15;

  typedef struct packed {
    logic               load;
    op_t                mul_op;
    op_t                wb_op;
  } cmd_t;

  typedef struct packed {
    logic [ERR_W-1:0]        err_window;
    logic [22:0]             sum_limit;
    logic signed [DRV_W-1:0] out_pos_limit;
    logic signed [DRV_W-1:0] out_neg_limit;
    logic [19:0]             kp_base;
    logic [23:0]             ki_base;
    logic [16:0]             bus_scale;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] target_speed;
    logic [SPEED_W-1:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic                    clamped;
    logic                    in_window;
  } out_item_t;

endpackage

// ===== design/gspi_regs.sv =====
// ----------------------------------------------------------------------------
// gspi_regs
// configuration register file, write only, with reset defaults
// ----------------------------------------------------------------------------
module gspi_regs import gspi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.err_window    <= ERR_W'(2000);
      cfg.sum_limit     <= 23'(801283);
      cfg.out_pos_limit <= DRV_W'(1100);
      cfg.out_neg_limit <= DRV_W'(-400);
      cfg.kp_base       <= 20'(19661);
      cfg.ki_base       <= 24'(40265);
      cfg.bus_scale     <= 17'(52036);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ERR_WINDOW: cfg.err_window    <= cfg_wdata[ERR_W-1:0];
        REG_SUM_LIMIT:  cfg.sum_limit     <= cfg_wdata[22:0];
        REG_OUT_POS:    cfg.out_pos_limit <= cfg_wdata[DRV_W-1:0];
        REG_OUT_NEG:    cfg.out_neg_limit <= cfg_wdata[DRV_W-1:0];
        REG_KP_BASE:    cfg.kp_base       <= cfg_wdata[19:0];
        REG_KI_BASE:    cfg.ki_base       <= cfg_wdata[23:0];
        REG_BUS_SCALE:  cfg.bus_scale     <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/gspi_ctrl.sv =====
// ----------------------------------------------------------------------------
// gspi_ctrl
// sequencer: steps the shared multiplier through one sample, owns the handshakes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gspi_ctrl import gspi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [3:0] LAST_STEP = 4'd14;

  logic [1:0] state, state_next;
  logic [3:0] step, step_next;
  logic       fin;
  logic       accept;

  // result slot free or being emptied this cycle
  assign fin      = (state == ST_DONE) && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) || fin;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (step == LAST_STEP) begin
          state_next = ST_DONE;
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_DONE: begin
        if (accept) begin
          state_next = ST_RUN;
          step_next  = '0;
        end else if (fin) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // step schedule: issue one product, write back the one issued in the step before
  always_comb begin
    cmd.load   = accept;
    cmd.mul_op = OP_NONE;
    cmd.wb_op  = fin ? OP_OUT : OP_NONE;
    if (state == ST_RUN) begin
      case (step)
        4'd0:  begin cmd.mul_op = OP_KPN;  cmd.wb_op = OP_NONE; end
        4'd1:  begin cmd.mul_op = OP_KIN;  cmd.wb_op = OP_KPN;  end
        4'd2:  begin cmd.mul_op = OP_KPE;  cmd.wb_op = OP_KIN;  end
        4'd3:  begin cmd.mul_op = OP_SKE;  cmd.wb_op = OP_KPE;  end
        4'd4:  begin cmd.mul_op = OP_KB;   cmd.wb_op = OP_SKE;  end
        4'd5:  begin cmd.mul_op = OP_KIB;  cmd.wb_op = OP_KB;   end
        4'd6:  begin cmd.mul_op = OP_KP1;  cmd.wb_op = OP_KIB;  end
        4'd7:  begin cmd.mul_op = OP_KI1;  cmd.wb_op = OP_KP1;  end
        4'd8:  begin cmd.mul_op = OP_KP2;  cmd.wb_op = OP_KI1;  end
        4'd9:  begin cmd.mul_op = OP_INC;  cmd.wb_op = OP_KP2;  end
        4'd10: begin cmd.mul_op = OP_P;    cmd.wb_op = OP_INC;  end
        4'd11: begin cmd.mul_op = OP_IH;   cmd.wb_op = OP_P;    end
        4'd12: begin cmd.mul_op = OP_IL;   cmd.wb_op = OP_IH;   end
        4'd13: begin cmd.mul_op = OP_NONE; cmd.wb_op = OP_IL;   end
        4'd14: begin cmd.mul_op = OP_NONE; cmd.wb_op = OP_ITR;  end
        default: begin cmd.mul_op = OP_NONE; cmd.wb_op = OP_NONE; end
      endcase
    end
  end

  // checks
  `GSPI_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == ST_RUN && step == 4'd0, "accepted beat did not start the sequence")
  `GSPI_ASSERT_NEXT(a_stall_holds, state == ST_DONE && out_valid && !out_ready, state == ST_DONE && out_valid, "finished sample lost under stall")
  `GSPI_ASSERT_NOW(a_busy_not_ready, state == ST_RUN, !in_ready, "ready raised mid sequence")

endmodule

// ===== design/gspi_dp.sv =====
// ----------------------------------------------------------------------------
// gspi_dp
// datapath: error stage, one shared 37x19 multiplier, gain and integral regs
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gspi_dp import gspi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  output out_item_t out_data
);

  // per-sample registers
  logic [SPEED_W-1:0]      tgt;
  logic signed [ERR_W-1:0] e;
  logic [AC_W-1:0]         ac;
  logic                    inwin;
  logic [FAC_W-1:0]        kpn, kin, kpe, ske;
  logic [KP_W-1:0]         kt;
  logic [KI_W-1:0]         ki;
  logic signed [ACC_W-1:0] acc;
  logic signed [P_W-1:0]   p;
  logic signed [IT_W-1:0]  itrm;
  logic signed [PROD_W-1:0] prod;

  // integral state, kept across samples
  logic signed [SUM_W-1:0] integral;

  // error, magnitude, window test and clamped magnitude of the incoming beat
  logic signed [ERR_W-1:0] e_in;
  logic [ERR_W-1:0]        ae_in;
  logic [AC_W-1:0]         ac_in;

  assign e_in  = $signed({1'b0, in_data.target_speed}) - $signed({1'b0, in_data.measured_speed});
  assign ae_in = e_in[ERR_W-1] ? ERR_W'(-e_in) : ERR_W'(e_in);

  always_comb begin
    if (ae_in < ERR_W'(ERR_LO)) begin
      ac_in = ERR_LO;
    end else if (ae_in > ERR_W'(ERR_HI)) begin
      ac_in = ERR_HI;
    end else begin
      ac_in = ae_in[AC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt   <= in_data.target_speed;
      e     <= e_in;
      ac    <= ac_in;
      inwin <= ae_in < cfg.err_window;
    end
  end

  // shared multiplier operand select
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      OP_KPN: begin mul_a = K_KPN; mul_b = MB_W'(tgt); end
      OP_KIN: begin mul_a = K_KIN; mul_b = MB_W'(tgt); end
      OP_KPE: begin mul_a = K_KPE; mul_b = MB_W'(ac); end
      OP_SKE: begin mul_a = K_SKE; mul_b = MB_W'(ac); end
      OP_KB:  begin mul_a = MA_W'(cfg.kp_base); mul_b = MB_W'(cfg.bus_scale); end
      OP_KIB: begin mul_a = MA_W'(cfg.ki_base); mul_b = MB_W'(cfg.bus_scale); end
      OP_KP1: begin mul_a = MA_W'(kt); mul_b = MB_W'(kpe); end
      OP_KI1: begin mul_a = MA_W'(ki); mul_b = MB_W'(kin); end
      OP_KP2: begin mul_a = MA_W'(kt); mul_b = MB_W'(kpn); end
      OP_INC: begin mul_a = MA_W'(e); mul_b = MB_W'(ske); end
      OP_P:   begin mul_a = MA_W'(kt); mul_b = MB_W'(e); end
      OP_IH:  begin mul_a = MA_W'(integral); mul_b = MB_W'(ki[KI_W-1:KI_LO_W]); end
      OP_IL:  begin mul_a = MA_W'(integral); mul_b = MB_W'(ki[KI_LO_W-1:0]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // piecewise-linear factor: offset, clamp, drop to q16
  logic signed [FV_W-1:0] fb, flo, fhi, fv, fc;
  logic [FAC_W-1:0]       fac;

  always_comb begin
    case (cmd.wb_op)
      OP_KPN:  begin fb = B_KPN; flo = LO_KPN; fhi = HI_KPN; end
      OP_KIN:  begin fb = B_KIN; flo = LO_KIN; fhi = HI_KIN; end
      OP_KPE:  begin fb = B_KPE; flo = LO_KPE; fhi = HI_KPE; end
      default: begin fb = B_SKE; flo = LO_SKE; fhi = HI_SKE; end
    endcase
    fv = $signed(prod[FV_W-1:0]) + fb;
    if (fv > fhi) begin
      fc = fhi;
    end else if (fv < flo) begin
      fc = flo;
    end else begin
      fc = fv;
    end
    fac = fc[FAC_W+15:16];
  end

  // integral increment, truncated toward zero to q8
  logic signed [31:0]       inc_raw, inc_bias;
  logic signed [23:0]       inc;
  logic signed [SUM_W-1:0]  lim_s;
  logic                     grow;

  assign inc_raw  = prod[31:0];
  assign inc_bias = inc_raw + (inc_raw[31] ? 32'sd255 : 32'sd0);
  assign inc      = inc_bias[31:8];
  assign lim_s    = $signed({{(SUM_W-31){1'b0}}, cfg.sum_limit, 8'd0});
  assign grow     = (e > 15'sd0 && integral < lim_s) || (e < 15'sd0 && integral > -lim_s);

  // proportional term, truncated toward zero to an integer
  logic signed [P_W+15:0] p_raw, p_bias;

  assign p_raw  = prod[P_W+15:0];
  assign p_bias = p_raw + (p_raw[P_W+15] ? (P_W+16)'(65535) : (P_W+16)'(0));

  // integral term, truncated toward zero to an integer
  logic signed [ACC_W-1:0] it_bias;

  assign it_bias = acc + (acc[ACC_W-1] ? ACC_W'(64'sd4294967295) : ACC_W'(0));

  // output sum and clamp, upper limit tested first
  logic signed [OSUM_W-1:0] osum;
  logic signed [OSUM_W-1:0] pos_x, neg_x;

  assign osum  = OSUM_W'(p) + OSUM_W'(itrm);
  assign pos_x = OSUM_W'(cfg.out_pos_limit);
  assign neg_x = OSUM_W'(cfg.out_neg_limit);

  // writeback of the product issued in the step before, plus the integral term and output
  always_ff @(posedge clk) begin
    case (cmd.wb_op)
      OP_KPN: kpn <= fac;
      OP_KIN: kin <= fac;
      OP_KPE: kpe <= fac;
      OP_SKE: ske <= fac;
      OP_KB:  kt  <= KP_W'(prod[36:16]);
      OP_KIB: ki  <= KI_W'(prod[40:16]);
      OP_KP1: kt  <= prod[KP_W+15:16];
      OP_KI1: ki  <= prod[KI_W+15:16];
      OP_KP2: kt  <= prod[KP_W+15:16];
      // proportional action is off outside the window
      OP_P:   p   <= inwin ? p_bias[P_W+15:16] : '0;
      OP_IH:  acc <= {prod[ACC_W-KI_LO_W-1:0], {KI_LO_W{1'b0}}};
      OP_IL:  acc <= acc + ACC_W'(prod);
      OP_ITR: itrm <= it_bias[ACC_W-1:32];
      OP_OUT: begin
        out_data.in_window <= inwin;
        if (osum > pos_x) begin
          out_data.drive   <= cfg.out_pos_limit;
          out_data.clamped <= 1'b1;
        end else if (osum < neg_x) begin
          out_data.drive   <= cfg.out_neg_limit;
          out_data.clamped <= 1'b1;
        end else begin
          out_data.drive   <= osum[DRV_W-1:0];
          out_data.clamped <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // integral update: accumulate inside the window while within the sum limit, clear outside it
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (cmd.wb_op == OP_INC) begin
      if (!inwin) begin
        integral <= '0;
      end else if (grow) begin
        integral <= integral + SUM_W'(inc);
      end
    end
  end

  // checks
  `GSPI_ASSERT_NEXT(a_window_clears, cmd.wb_op == OP_INC && !inwin, integral == '0, "integral not cleared outside window")
  `GSPI_ASSERT_NEXT(a_p_off_outside, cmd.wb_op == OP_P && !inwin, p == '0, "proportional term live outside window")
  `GSPI_ASSERT_NOW(a_kpe_range, cmd.wb_op == OP_KPE, fac >= FAC_W'(65536) && fac <= FAC_W'(196608), "error gain factor out of range")

endmodule

// ===== design/gain_scheduled_pi_speed_loop_top.sv =====
// ----------------------------------------------------------------------------
// gain_scheduled_pi_speed_loop_top
// gain-scheduled pi speed controller with clamped output
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) takes one beat per control period
//   holding target and measured speed. out channel (out_valid/out_ready/
//   out_data) returns one beat per input: drive, clamped and in_window.
//   config is a plain write port (cfg_wr_en, cfg_addr, cfg_wdata); write
//   only while no sample is in flight.
// sequencing:
//   the result is produced by the sequencer, which runs 15 steps through a
//   single shared 37x19 multiplier, then sums, clamps and loads the output
//   register. a new beat is taken only once the previous sample's result is
//   being loaded, so only one sample is in flight at a time.
// reset:
//   rst returns all config registers to their defaults, clears the integral
//   and drops any pending result.
// stall:
//   a finished result sits in the output register until taken; the next
//   input beat is accepted meanwhile and its work holds in the done state,
//   after the last step, until the output register frees up.
// ----------------------------------------------------------------------------
module gain_scheduled_pi_speed_loop_top import gspi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  cfg_t cfg;
  cmd_t cmd;

  // configuration registers
  gspi_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer
  gspi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic
  gspi_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
